FILE: rtl/wavetable_note_player_with_envelope_core_defines.svh
// Assertion macros shared by the wavetable note player modules.
`ifndef WAVETABLE_NOTE_PLAYER_WITH_ENVELOPE_CORE_DEFINES_SVH
`define WAVETABLE_NOTE_PLAYER_WITH_ENVELOPE_CORE_DEFINES_SVH

`define WTNP_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

`define WTNP_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

FILE: rtl/wtnp_pkg.sv
// Types, codes and constant tables of the wavetable note player.
package wtnp_pkg;

  localparam int unsigned SONG_NOTES   = 112;
  localparam int unsigned RHYTHM_STEPS = 14;
  localparam int unsigned WAVE_POINTS  = 32;
  localparam int unsigned NOTE_W       = $clog2(SONG_NOTES);
  localparam int unsigned DUR_W        = $clog2(RHYTHM_STEPS);
  localparam int unsigned WAVE_W       = $clog2(WAVE_POINTS);

  localparam int unsigned DIV_W        = 32;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  localparam logic [5:0]  MIDPOINT_VAL = 6'd32;

  localparam logic [19:0] IDLE_PERIOD_RESET = 20'd800000;
  localparam logic [26:0] INITIAL_WAIT_RESET = 27'h1000000;
  localparam logic [9:0]  ATTACK_STEP_RESET = 10'd32;
  localparam logic [9:0]  DECAY_STEP_RESET  = 10'd500;
  localparam logic [4:0]  ENV_PEAK_RESET    = 5'd24;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] SONG_THEME = 2'd1;

  localparam logic [2:0] REG_IDLE_PERIOD  = 3'd0;
  localparam logic [2:0] REG_INITIAL_WAIT = 3'd1;
  localparam logic [2:0] REG_ATTACK_STEP  = 3'd2;
  localparam logic [2:0] REG_DECAY_STEP   = 3'd3;
  localparam logic [2:0] REG_ENV_PEAK     = 3'd4;

  localparam logic [26:0] BEAT_TICKS = 27'h434A900;
  localparam logic [26:0] DUR_HALF   = BEAT_TICKS >> 1;
  localparam logic [26:0] DUR_QTR    = BEAT_TICKS >> 2;

  localparam logic [13:0] PA   = 14'd5682;
  localparam logic [13:0] PB   = 14'd5062;
  localparam logic [13:0] PCS  = 14'd4510;
  localparam logic [13:0] PD   = 14'd4257;
  localparam logic [13:0] PE   = 14'd3792;
  localparam logic [13:0] PFS  = 14'd3378;
  localparam logic [13:0] PG   = 14'd3189;
  localparam logic [13:0] PAH  = 14'd2841;
  localparam logic [13:0] PFSL = 14'd6757;
  localparam logic [13:0] PGL  = 14'd6378;
  localparam logic [13:0] PEL  = 14'd7584;
  localparam logic [13:0] PDL  = 14'd8513;

  localparam logic [13:0] NOTE_PERIOD_ROM [0:SONG_NOTES-1] = '{
    PAH, PFS, PG, PAH, PFS, PG, PAH, PA, PB, PCS, PD, PE, PFS, PG,
    PFS, PD, PE, PFS, PFSL, PGL, PA, PB, PA, PGL, PA, PFSL, PGL, PA,
    PGL, PB, PA, PGL, PFSL, PEL, PFSL, PEL, PDL, PEL, PFSL, PGL, PA, PB,
    PGL, PB, PA, PB, PCS, PD, PA, PB, PCS, PD, PE, PFS, PG, PAH,
    PFS, PD, PE, PFS, PE, PD, PE, PA, PB, PE, PFS, PE, PD, PCS,
    PD, PB, PCS, PD, PDL, PEL, PFSL, PGL, PFSL, PEL, PFSL, PD, PCS, PD,
    PB, PD, PCS, PB, PA, PGL, PA, PGL, PFSL, PGL, PA, PB, PCS, PD,
    PB, PD, PCS, PD, PCS, PB, PCS, PD, PE, PD, PCS, PD, PB, PCS};

  localparam logic [26:0] DURATION_ROM [0:RHYTHM_STEPS-1] = '{
    DUR_HALF, DUR_QTR, DUR_QTR, DUR_HALF, DUR_QTR, DUR_QTR, DUR_QTR,
    DUR_QTR, DUR_QTR, DUR_QTR, DUR_QTR, DUR_QTR, DUR_QTR, DUR_QTR};

  localparam logic [5:0] WAVE_ROM [0:WAVE_POINTS-1] = '{
    6'd32, 6'd33, 6'd35, 6'd36, 6'd37, 6'd38, 6'd38, 6'd39,
    6'd39, 6'd39, 6'd38, 6'd38, 6'd37, 6'd36, 6'd35, 6'd33,
    6'd32, 6'd31, 6'd29, 6'd28, 6'd27, 6'd26, 6'd26, 6'd25,
    6'd25, 6'd25, 6'd26, 6'd26, 6'd27, 6'd28, 6'd29, 6'd31};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic take_event;
    logic tick_now;
    logic div_start;
    logic div_step;
    logic tick_sample;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_tick;
    logic item_event;
    logic sample_due;
    logic div_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

FILE: rtl/wtnp_ctrl.sv
// Controller state machine that sequences ticks, events and the envelope divider.
`include "wavetable_note_player_with_envelope_core_defines.svh"

module wtnp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wtnp_pkg::ctrl_stat_t stat,
  output wtnp_pkg::ctrl_cmd_t  cmd
);

  wtnp_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtnp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wtnp_pkg::ST_IDLE: begin
        if (in_valid && stat.item_tick && stat.sample_due) begin
          state_next = wtnp_pkg::ST_DIV;
        end
      end
      wtnp_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_next = wtnp_pkg::ST_FINISH;
        end
      end
      wtnp_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          state_next = wtnp_pkg::ST_IDLE;
        end
      end
      default: state_next = wtnp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      wtnp_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.take_event = in_valid && stat.item_event;
        cmd.tick_now   = in_valid && stat.item_tick && !stat.sample_due;
        cmd.div_start  = in_valid && stat.item_tick && stat.sample_due;
      end
      wtnp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      wtnp_pkg::ST_FINISH: begin
        cmd.tick_sample = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `WTNP_ASSERT_NEXT(a_div_follows_start, cmd.div_start, state == wtnp_pkg::ST_DIV, "divider did not start")
  `WTNP_ASSERT_NEXT(a_finish_holds, (state == wtnp_pkg::ST_FINISH) && !stat.out_free, state == wtnp_pkg::ST_FINISH, "sample left before output slot was free")

endmodule

FILE: rtl/wtnp_dp.sv
// Datapath: configuration registers, countdowns, envelope divider and output register.
`include "wavetable_note_player_with_envelope_core_defines.svh"

module wtnp_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  input  logic [1:0]          kind,
  input  logic [1:0]          song_select,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          out_sample,
  input  wtnp_pkg::ctrl_cmd_t  cmd,
  output wtnp_pkg::ctrl_stat_t stat
);

  logic [19:0] idle_sample_period;
  logic [26:0] initial_wait;
  logic [9:0]  attack_step;
  logic [9:0]  decay_step;
  logic [4:0]  envelope_peak;

  logic                        playing;
  logic                        in_decay;
  logic [19:0]                 sample_countdown;
  logic [19:0]                 sample_period;
  logic [26:0]                 note_countdown;
  logic [wtnp_pkg::NOTE_W-1:0] note_pointer;
  logic [wtnp_pkg::DUR_W-1:0]  duration_pointer;
  logic [wtnp_pkg::WAVE_W-1:0] wave_pointer;
  logic [15:0]                 attack_count;
  logic [31:0]                 decay_count;

  logic [wtnp_pkg::DIV_W-1:0]     div_num;
  logic [9:0]                     div_rem;
  logic [9:0]                     div_den;
  logic [wtnp_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [10:0]                    rem_sh;
  logic                           rem_ge;
  logic [10:0]                    rem_next;
  logic [9:0]                     step_sel;

  logic              cfg_wr;
  logic              tick_any;
  logic              note_fire;
  logic [5:0]        wave_val;
  logic              above;
  logic              below;
  logic              att_ge;
  logic [4:0]        att_m;
  logic signed [9:0] v;
  logic signed [9:0] att_r;
  logic signed [9:0] up_raw;
  logic signed [9:0] dn_raw;
  logic signed [9:0] up_s8;
  logic signed [9:0] dn_s8;
  logic signed [9:0] dec_r;
  logic signed [9:0] env_r;
  logic [5:0]        shaped;

  assign cfg_wr    = psel && penable && pwrite;
  assign tick_any  = cmd.tick_now || cmd.tick_sample;
  assign note_fire = note_countdown <= 27'd1;

  assign stat.item_tick  = kind == wtnp_pkg::KIND_TICK;
  assign stat.item_event = (kind == wtnp_pkg::KIND_START) || (kind == wtnp_pkg::KIND_STOP);
  assign stat.sample_due = sample_countdown <= 20'd1;
  assign stat.div_last   = div_cnt == wtnp_pkg::DIV_LAST;
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      wtnp_pkg::REG_IDLE_PERIOD:  prdata = {12'd0, idle_sample_period};
      wtnp_pkg::REG_INITIAL_WAIT: prdata = {5'd0, initial_wait};
      wtnp_pkg::REG_ATTACK_STEP:  prdata = {22'd0, attack_step};
      wtnp_pkg::REG_DECAY_STEP:   prdata = {22'd0, decay_step};
      wtnp_pkg::REG_ENV_PEAK:     prdata = {27'd0, envelope_peak};
      default:                    prdata = '0;
    endcase
  end

  assign step_sel = in_decay ? decay_step : attack_step;
  assign rem_sh   = {div_rem, div_num[wtnp_pkg::DIV_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, div_den};
  assign rem_next = rem_ge ? (rem_sh - {1'b0, div_den}) : rem_sh;

  always_comb begin
    wave_val = wtnp_pkg::WAVE_ROM[wave_pointer];
    above    = wave_val > wtnp_pkg::MIDPOINT_VAL;
    below    = wave_val < wtnp_pkg::MIDPOINT_VAL;
    v        = signed'({4'd0, wave_val});
    att_ge   = div_num >= {27'd0, envelope_peak};
    att_m    = att_ge ? envelope_peak : div_num[4:0];
    if (above) begin
      att_r = v + signed'({5'd0, att_m});
    end else if (below) begin
      att_r = v - signed'({5'd0, att_m});
    end else begin
      att_r = v;
    end
    up_raw = v + signed'({5'd0, envelope_peak}) - signed'({2'd0, div_num[7:0]});
    dn_raw = v - signed'({5'd0, envelope_peak}) + signed'({2'd0, div_num[7:0]});
    up_s8  = signed'({{2{up_raw[7]}}, up_raw[7:0]});
    dn_s8  = signed'({{2{dn_raw[7]}}, dn_raw[7:0]});
    if (above) begin
      dec_r = (up_s8 < 10'sd32) ? 10'sd32 : up_s8;
    end else if (below) begin
      dec_r = (dn_s8 > 10'sd32) ? 10'sd32 : dn_s8;
    end else begin
      dec_r = v;
    end
    env_r = in_decay ? dec_r : att_r;
    if (env_r < 10'sd0) begin
      shaped = 6'd0;
    end else if (env_r > 10'sd63) begin
      shaped = 6'd63;
    end else begin
      shaped = env_r[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num <= in_decay ? decay_count : {16'd0, attack_count};
      div_rem <= '0;
      div_den <= (step_sel == 10'd0) ? 10'd1 : step_sel;
    end else if (cmd.div_step) begin
      div_num <= {div_num[wtnp_pkg::DIV_W-2:0], rem_ge};
      div_rem <= rem_next[9:0];
    end
    if (cmd.tick_sample) begin
      out_sample <= shaped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_sample_period <= wtnp_pkg::IDLE_PERIOD_RESET;
      initial_wait       <= wtnp_pkg::INITIAL_WAIT_RESET;
      attack_step        <= wtnp_pkg::ATTACK_STEP_RESET;
      decay_step         <= wtnp_pkg::DECAY_STEP_RESET;
      envelope_peak      <= wtnp_pkg::ENV_PEAK_RESET;
      playing            <= 1'b0;
      in_decay           <= 1'b0;
      sample_countdown   <= wtnp_pkg::IDLE_PERIOD_RESET;
      sample_period      <= wtnp_pkg::IDLE_PERIOD_RESET;
      note_countdown     <= '0;
      note_pointer       <= '0;
      duration_pointer   <= '0;
      wave_pointer       <= '0;
      attack_count       <= '0;
      decay_count        <= '0;
      div_cnt            <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.tick_sample) begin
        out_valid <= 1'b1;
      end

      if (cmd.div_start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end

      if (cmd.take_event) begin
        if (kind == wtnp_pkg::KIND_START) begin
          if ((song_select == wtnp_pkg::SONG_THEME) && !playing) begin
            playing          <= 1'b1;
            note_pointer     <= '0;
            duration_pointer <= '0;
            note_countdown   <= initial_wait;
          end
        end else begin
          playing <= 1'b0;
        end
      end

      if (cmd.tick_now) begin
        sample_countdown <= sample_countdown - 20'd1;
      end

      if (cmd.tick_sample) begin
        wave_pointer     <= wave_pointer + 1'b1;
        sample_countdown <= sample_period;
        if (!in_decay) begin
          if (att_ge) begin
            in_decay     <= 1'b1;
            attack_count <= '0;
          end else begin
            attack_count <= attack_count + 16'd1;
          end
        end else begin
          decay_count <= decay_count + 32'd1;
        end
      end

      if (tick_any && playing) begin
        if (note_fire) begin
          note_countdown   <= wtnp_pkg::DURATION_ROM[duration_pointer];
          duration_pointer <= (duration_pointer == wtnp_pkg::DUR_W'(wtnp_pkg::RHYTHM_STEPS - 1))
                              ? '0 : duration_pointer + 1'b1;
          sample_period    <= {6'd0, wtnp_pkg::NOTE_PERIOD_ROM[note_pointer]};
          note_pointer     <= (note_pointer == wtnp_pkg::NOTE_W'(wtnp_pkg::SONG_NOTES - 1))
                              ? '0 : note_pointer + 1'b1;
          attack_count     <= '0;
          decay_count      <= '0;
          in_decay         <= 1'b0;
        end else begin
          note_countdown <= note_countdown - 27'd1;
        end
      end

      if (cfg_wr) begin
        case (paddr[4:2])
          wtnp_pkg::REG_IDLE_PERIOD: begin
            idle_sample_period <= pwdata[19:0];
            sample_period      <= pwdata[19:0];
            sample_countdown   <= pwdata[19:0];
          end
          wtnp_pkg::REG_INITIAL_WAIT: initial_wait  <= pwdata[26:0];
          wtnp_pkg::REG_ATTACK_STEP:  attack_step   <= pwdata[9:0];
          wtnp_pkg::REG_DECAY_STEP:   decay_step    <= pwdata[9:0];
          wtnp_pkg::REG_ENV_PEAK:     envelope_peak <= pwdata[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  `WTNP_ASSERT_NEXT(a_wave_advance, cmd.tick_sample, wave_pointer == ($past(wave_pointer) + 1'b1), "wave pointer did not advance on a sample")
  `WTNP_ASSERT_NEXT(a_countdown_reload, cmd.tick_sample && !cfg_wr, sample_countdown == $past(sample_period), "sample countdown not reloaded from the old period")
  `WTNP_ASSERT_IMPL(a_stop_only_by_event, $fell(playing), $past(cmd.take_event), "song stopped without a stop transfer")

endmodule

FILE: rtl/wavetable_note_player_with_envelope_core.sv
// Top level of the wavetable note player with attack/decay envelope.
// Each input transfer is one time tick or a start/stop event. Events and ticks on which no
// sample falls are handled as the transfer is taken. A tick on which the sample countdown
// expires takes the transfer, then runs the 32 steps of the bit-serial divider that forms the
// envelope offset from the attack or decay counter, and then shapes the sample and updates
// all counters; that last step waits while the output register still holds an untaken
// sample. The input is held not ready from the first divider step through the shaping cycle.
module wavetable_note_player_with_envelope_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] song_select, [7:2] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] sample, [7:6] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  wtnp_pkg::ctrl_cmd_t  cmd;
  wtnp_pkg::ctrl_stat_t stat;
  logic [5:0]           sample;

  assign pready       = 1'b1;
  assign m_axis_tdata = {2'd0, sample};

  wtnp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wtnp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .kind        (s_axis_tuser),
    .song_select (s_axis_tdata[1:0]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_sample  (sample),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
